// ----- sv/ffra_pkg.sv -----
// Package for the first-fit room allocator: request and result beat types,
// default sizes and the controller state encoding. No dependencies.
`default_nettype none

package ffra_pkg;

    localparam int MAX_ROOMS_DEF  = 1024;
    localparam int GROUP_SIZE_DEF = 256;
    localparam int TAG_W          = 20;
    localparam int TIME_W         = 32;
    localparam int CNT_W          = 11;

    typedef struct packed {
        logic [TAG_W-1:0]  customer_tag;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } t_request;

    typedef struct packed {
        logic [TAG_W-1:0] customer_tag_res;
        logic [CNT_W-1:0] room_number;
        logic [CNT_W-1:0] rooms_in_use;
        logic             full_res;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SELECT,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

// ----- sv/ffra_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/first_fit_room_allocator.sv -----
// Top level of the first-fit room allocator: group minima in flip-flops, the
// per-room free-from times in one ffra_ram. Depends on ffra_pkg and ffra_ram.
`default_nettype none

// A request is taken when start is high and busy is low, and its result beat
// appears for one cycle with o_done in the cycle after the work ends; the
// result cannot be held off. A request that opens a new room, or finds every
// room taken, keeps the block busy in S_SELECT only. A request that reuses a
// room keeps it busy through S_SELECT and then S_SCAN, which reads the L opened
// rooms of the first group whose minimum free-from time fits (L is at most
// GROUP_SIZE, so 256 at the default sizes) through the single read port of the
// room memory, one room a cycle, to place the booking and rebuild that group's
// minimum in the same pass. The room memory needs no clearing after reset.
module first_fit_room_allocator #(
    parameter int MAX_ROOMS  = ffra_pkg::MAX_ROOMS_DEF,
    parameter int GROUP_SIZE = ffra_pkg::GROUP_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ffra_pkg::t_request i_req,
    output logic               busy,
    output logic               o_done,
    output ffra_pkg::t_result  o_res
);

    import ffra_pkg::*;

    localparam int NG  = (MAX_ROOMS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int AW  = $clog2(MAX_ROOMS);
    localparam int CW  = $clog2(MAX_ROOMS + 1);
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int GCW = $clog2(NG + 1);
    localparam int OW  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int LW  = $clog2(GROUP_SIZE + 1);

    t_state r_state, n_state;

    // Control state.
    logic [CW-1:0]     r_count, n_count;
    logic [GCW-1:0]    r_open_group, n_open_group;
    logic [OW-1:0]     r_open_off, n_open_off;
    logic [TIME_W-1:0] r_gmin [NG];
    logic [TIME_W-1:0] n_gmin [NG];
    logic              r_done, n_done;
    logic              r_rd_vld, n_rd_vld;
    logic              r_hit, n_hit;

    // Request and scan payload.
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_next, n_next;
    logic [GW-1:0]     r_grp, n_grp;
    logic [AW-1:0]     r_base, n_base;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_rd_last, n_rd_last;
    logic [AW-1:0]     r_hit_addr, n_hit_addr;
    logic [TIME_W-1:0] r_min, n_min;
    t_result           r_res, n_res;

    logic [NG-1:0]     w_grp_hit;
    logic              w_found;
    logic [GW-1:0]     w_sel;
    logic [AW-1:0]     w_base;
    logic [LW-1:0]     w_len;
    logic              w_full;
    logic [CW-1:0]     w_count_inc;
    logic              w_issue;
    logic              w_take;
    logic [TIME_W-1:0] w_cand;
    logic [TIME_W-1:0] w_min;
    logic [AW-1:0]     w_room_addr;
    logic [AW:0]       w_room_num;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [TIME_W-1:0] w_rdata;

    ffra_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ROOMS)
    ) u_room_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_next),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A group takes part only once it holds at least one opened room.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_grp_hit[g] = ((GCW'(g) < r_open_group)
                            || ((GCW'(g) == r_open_group) && (r_open_off != '0)))
                           && (r_start >= r_gmin[g]);
        end
    end

    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (w_grp_hit[g]) begin
                w_found = 1'b1;
                w_sel   = GW'(g);
            end
        end
    end

    assign w_base      = AW'(w_sel * GROUP_SIZE);
    assign w_len       = (GCW'(w_sel) < r_open_group) ? LW'(GROUP_SIZE) : LW'(r_open_off);
    assign w_full      = (r_count == CW'(MAX_ROOMS));
    assign w_count_inc = r_count + CW'(1);

    // Scan datapath: the first room that fits takes the booking, and the group
    // minimum is rebuilt from the values as they stand after that write.
    assign w_issue     = (r_state == S_SCAN) && (r_idx < r_len);
    assign w_raddr     = r_base + AW'(r_idx);
    assign w_take      = (r_state == S_SCAN) && r_rd_vld && !r_hit && (r_start >= w_rdata);
    assign w_cand      = w_take ? r_next : w_rdata;
    assign w_min       = (w_cand < r_min) ? w_cand : r_min;
    assign w_room_addr = w_take ? r_rd_addr : r_hit_addr;
    assign w_room_num  = {1'b0, w_room_addr} + (AW + 1)'(1);

    assign w_we    = ((r_state == S_SELECT) && !w_found && !w_full) || w_take;
    assign w_waddr = w_take ? r_rd_addr : AW'(r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SELECT;
                end
            end
            S_SELECT: begin
                n_state = w_found ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (r_rd_vld && r_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result beat.
    always_comb begin
        n_count      = r_count;
        n_open_group = r_open_group;
        n_open_off   = r_open_off;
        n_gmin       = r_gmin;
        n_done       = 1'b0;
        n_rd_vld     = 1'b0;
        n_hit        = r_hit;
        n_tag        = r_tag;
        n_start      = r_start;
        n_next       = r_next;
        n_grp        = r_grp;
        n_base       = r_base;
        n_len        = r_len;
        n_idx        = r_idx;
        n_rd_addr    = r_rd_addr;
        n_rd_last    = r_rd_last;
        n_hit_addr   = r_hit_addr;
        n_min        = r_min;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_tag   = i_req.customer_tag;
                    n_start = i_req.start_time;
                    // End plus one saturates at all ones.
                    n_next  = (i_req.end_time == '1) ? i_req.end_time
                                                     : i_req.end_time + TIME_W'(1);
                end
            end
            S_SELECT: begin
                n_grp  = w_sel;
                n_base = w_base;
                n_len  = w_len;
                n_idx  = '0;
                n_min  = '1;
                n_hit  = 1'b0;
                n_res.customer_tag_res = r_tag;
                if (!w_found) begin
                    n_done = 1'b1;
                    if (w_full) begin
                        n_res.room_number  = '0;
                        n_res.rooms_in_use = CNT_W'(r_count);
                        n_res.full_res     = 1'b1;
                    end else begin
                        n_count = w_count_inc;
                        if (r_next < r_gmin[r_open_group[GW-1:0]]) begin
                            n_gmin[r_open_group[GW-1:0]] = r_next;
                        end
                        if ((LW'(r_open_off) + LW'(1)) == LW'(GROUP_SIZE)) begin
                            n_open_off   = '0;
                            n_open_group = r_open_group + GCW'(1);
                        end else begin
                            n_open_off = r_open_off + OW'(1);
                        end
                        n_res.room_number  = CNT_W'(w_count_inc);
                        n_res.rooms_in_use = CNT_W'(w_count_inc);
                        n_res.full_res     = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld  = w_issue;
                n_rd_addr = w_raddr;
                n_rd_last = ((r_idx + LW'(1)) == r_len);
                if (w_issue) begin
                    n_idx = r_idx + LW'(1);
                end
                if (r_rd_vld) begin
                    n_min = w_min;
                    if (w_take) begin
                        n_hit      = 1'b1;
                        n_hit_addr = r_rd_addr;
                    end
                    if (r_rd_last) begin
                        n_gmin[r_grp]      = w_min;
                        n_done             = 1'b1;
                        n_res.room_number  = CNT_W'(w_room_num);
                        n_res.rooms_in_use = CNT_W'(r_count);
                        n_res.full_res     = 1'b0;
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_open_group <= '0;
            r_open_off   <= '0;
            r_done       <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            for (int g = 0; g < NG; g++) begin
                r_gmin[g] <= '1;
            end
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_open_group <= n_open_group;
            r_open_off   <= n_open_off;
            r_done       <= n_done;
            r_rd_vld     <= n_rd_vld;
            r_hit        <= n_hit;
            r_gmin       <= n_gmin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_start    <= n_start;
        r_next     <= n_next;
        r_grp      <= n_grp;
        r_base     <= n_base;
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_rd_addr  <= n_rd_addr;
        r_rd_last  <= n_rd_last;
        r_hit_addr <= n_hit_addr;
        r_min      <= n_min;
        r_res      <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_room_allocator: directed and random booking beats,
// an in-bench first-fit predictor and a result checker. Depends on ffra_pkg and the RTL.

module tb_top;
    import ffra_pkg::*;

    localparam int MAX_ROOMS    = MAX_ROOMS_DEF;
    localparam int GROUP_SIZE   = GROUP_SIZE_DEF;
    localparam int N_GROUPS     = (MAX_ROOMS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int MAX_GAP      = 17;
    localparam int TAIL_CYCLES  = GROUP_SIZE + 20;
    localparam int CYCLE_LIMIT  = 1_600_000;
    localparam int RANDOM_ITEMS = 1150;
    localparam logic [TIME_W-1:0] TOP_TIME = 32'hFFFF_FFFE;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_done;
    t_result  o_res;

    first_fit_room_allocator #(
        .MAX_ROOMS  (MAX_ROOMS),
        .GROUP_SIZE (GROUP_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the allocator state.
    logic [TIME_W-1:0] free_from   [MAX_ROOMS];
    logic [TIME_W-1:0] group_floor [N_GROUPS];
    int unsigned       rooms_open;
    int unsigned       reuse_hits;
    int unsigned       fresh_rooms;
    int unsigned       full_refusals;

    t_request          bookings_pending [$];
    t_result           replies_due [$];
    t_result           reply_want;
    logic [TIME_W-1:0] day_cursor;
    int unsigned       random_sent;
    int unsigned       directed_n;
    int unsigned       beats_accepted;
    int unsigned       results_checked;
    int unsigned       mismatches;
    int unsigned       cycle_count;
    int unsigned       gap_left;
    int unsigned       calm_left;
    bit                beat_taken;

    function automatic t_result allocate_room(t_request rq);
        logic [TIME_W-1:0] next_free;
        logic [TIME_W-1:0] lowest;
        int unsigned       room;
        int unsigned       first;
        int unsigned       last;
        int unsigned       g;
        int unsigned       r;
        bit                placed;
        t_result           res;
        next_free = (rq.end_time == '1) ? rq.end_time : rq.end_time + 1'b1;
        room      = 0;
        placed    = 1'b0;
        res       = '0;
        // Only the first group whose minimum fits is scanned; its minimum is
        // rebuilt in the same pass, after the chosen room has been updated.
        for (g = 0; g < N_GROUPS && !placed && g * GROUP_SIZE < rooms_open; g++) begin
            if (rq.start_time >= group_floor[g]) begin
                first  = g * GROUP_SIZE;
                last   = (first + GROUP_SIZE < rooms_open) ? first + GROUP_SIZE : rooms_open;
                lowest = '1;
                for (r = first; r < last; r++) begin
                    if (room == 0 && rq.start_time >= free_from[r]) begin
                        free_from[r] = next_free;
                        room = r + 1;
                    end
                    if (free_from[r] < lowest)
                        lowest = free_from[r];
                end
                group_floor[g] = lowest;
                placed = 1'b1;
                reuse_hits++;
            end
        end
        if (!placed) begin
            if (rooms_open >= MAX_ROOMS) begin
                res.full_res = 1'b1;
                full_refusals++;
            end else begin
                free_from[rooms_open] = next_free;
                g = rooms_open / GROUP_SIZE;
                if (next_free < group_floor[g])
                    group_floor[g] = next_free;
                rooms_open++;
                room = rooms_open;
                fresh_rooms++;
            end
        end
        res.customer_tag_res = rq.customer_tag;
        res.room_number      = CNT_W'(room);
        res.rooms_in_use     = CNT_W'(rooms_open);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH cycle %0d beat %0d %s: got 0x%0h, expected 0x%0h",
                 cycle_count, results_checked, what, got, want);
    endtask

    function automatic logic [TIME_W-1:0] clamp_time(longint unsigned t);
        return (t > TOP_TIME) ? TOP_TIME : TIME_W'(t);
    endfunction

    function automatic void book(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] from,
                                 logic [TIME_W-1:0] upto);
        t_request rq;
        rq.customer_tag = tag;
        rq.start_time   = from;
        rq.end_time     = upto;
        bookings_pending = {bookings_pending, rq};
    endfunction

    // A run of bookings sorted by start from the cursor on. Equal starts carry
    // falling tags. Now and then a noise beat goes back in time, often with its
    // end before its start.
    function automatic void booking_run(int n, int max_step, int unsigned short_len,
                                        int long_pct);
        logic [TAG_W-1:0] tag;
        int unsigned      step;
        int unsigned      span;
        int               k;
        tag = '1;
        for (k = 0; k < n; k++) begin
            step       = $urandom_range(0, max_step);
            day_cursor = clamp_time(64'(day_cursor) + step);
            tag  = (step == 0 && tag != 0) ? TAG_W'($urandom_range(0, tag - 1))
                                           : TAG_W'($urandom);
            span = ($urandom_range(1, 100) <= long_pct) ? $urandom_range(5000, 2_000_000)
                                                        : $urandom_range(0, short_len);
            if ($urandom_range(1, 40) == 1) begin
                book(TAG_W'($urandom), TIME_W'($urandom_range(0, day_cursor)),
                     TIME_W'($urandom_range(0, day_cursor)));
                random_sent++;
            end
            book(tag, day_cursor, clamp_time(64'(day_cursor) + span));
            random_sent++;
        end
    endfunction

    // Moves the cursor past every booking made so far except the stuck ones.
    function automatic void leap();
        day_cursor = clamp_time(64'(day_cursor) + 2_100_000 + $urandom_range(0, 1 << 26));
    endfunction

    // Checked at the rising edge, where the sender's outputs are settled.
    task automatic settle();
        do
            @(posedge i_clk);
        while (bookings_pending.size() != 0 || start || replies_due.size() != 0);
        @(negedge i_clk);
    endtask

    // Sender: holds each beat until it is taken, then waits a drawn number of
    // cycles, with occasional stretches of back-to-back beats.
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !beat_taken)) begin
            if (start) begin
                if (calm_left > 0) begin
                    calm_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, MAX_GAP);
                    if ($urandom_range(1, 30) == 1)
                        calm_left = $urandom_range(20, 80);
                end
            end
            if (gap_left == 0 && bookings_pending.size() != 0) begin
                start <= 1'b1;
                i_req <= bookings_pending.pop_front();
            end else begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result with no booking waiting", o_res, '0);
                end else begin
                    reply_want = replies_due.pop_front();
                    if (o_res.customer_tag_res !== reply_want.customer_tag_res)
                        report_mismatch("customer_tag_res", o_res.customer_tag_res,
                                        reply_want.customer_tag_res);
                    if (o_res.room_number !== reply_want.room_number)
                        report_mismatch("room_number", o_res.room_number,
                                        reply_want.room_number);
                    if (o_res.rooms_in_use !== reply_want.rooms_in_use)
                        report_mismatch("rooms_in_use", o_res.rooms_in_use,
                                        reply_want.rooms_in_use);
                    if (o_res.full_res !== reply_want.full_res)
                        report_mismatch("full_res", o_res.full_res, reply_want.full_res);
                    results_checked++;
                end
            end else if (o_done !== 1'b0) begin
                report_mismatch("o_done unknown", o_done, '0);
            end
            if (start && busy === 1'b0) begin
                beat_taken = 1'b1;
                beats_accepted++;
                replies_due = {replies_due, allocate_room(i_req)};
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(negedge i_clk);
        $display("first_fit_room_allocator test failed");
        $finish;
    end

    initial begin
        int unsigned lap;
        foreach (group_floor[g])
            group_floor[g] = '1;
        rooms_open = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, ties, an end before its start, beats out of
        // order, end-plus-one saturation and a start of all ones.
        book(20'h00000, 0, 0);
        book(20'hFFFFF, 0, 0);
        book(20'h00007, 0, 32'hFFFF_FFFE);
        book(20'h00005, 1, 1);
        book(20'h00004, 1, 4);
        book(20'h00009, 2, 2);
        book(20'h00003, 20, 10);
        book(20'h00002, 5, 32'hFFFF_FFFF);
        book(20'h00001, 3, 8);
        book(20'hAAAAA, 32'h8000_0000, 32'h8000_0000);
        book(20'h55555, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
        book(20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        book(20'h0F0F0, 100, 100);
        book(20'h12345, 200, 32'h7FFF_FFFF);
        book(20'h6789A, 200, 32'h0000_FFFF);
        book(20'hF0F0F, 32'h5555_5555, 32'hAAAA_AAAA);
        directed_n = bookings_pending.size();
        settle();

        day_cursor = 1000;
        while (random_sent < 40) begin
            booking_run($urandom_range(8, 20), 8, 60, 5);
            leap();
        end

        // Rush: mostly long stays pile up until every room is taken and
        // bookings are refused; the short ones free rooms in later groups.
        lap = 0;
        while (full_refusals < 8 && lap < 40) begin
            booking_run(64, 2, 150, 90);
            settle();
            lap++;
        end
        leap();

        lap = 0;
        while (random_sent < RANDOM_ITEMS || lap < 3) begin
            booking_run($urandom_range(15, 40), 8, 200, 10);
            leap();
            lap++;
        end
        day_cursor = TOP_TIME - $urandom_range(0, 4000);
        booking_run(20, 8, 60, 20);

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Bookings accepted: %0d (%0d directed), results checked: %0d, mismatches: %0d.",
                 beats_accepted, directed_n, results_checked, mismatches);
        $display("Rooms reused %0d times, opened %0d times (%0d of %0d open), refused %0d times.",
                 reuse_hits, fresh_rooms, rooms_open, MAX_ROOMS, full_refusals);
        if (mismatches == 0)
            $display("first_fit_room_allocator test passed");
        else
            $display("first_fit_room_allocator test failed");
        $finish;
    end

endmodule

// ----- first_fit_room_allocator.f -----
sv/ffra_pkg.sv
sv/ffra_ram.sv
sv/first_fit_room_allocator.sv
dv/tb_top.sv
